[hdl/alsc_pkg.sv]
// Package for the audio level scope column generator: constants and shared types.
package alsc_pkg;

  localparam int unsigned COLUMNS_DEFAULT = 43;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MASK_W = 7;
  localparam int unsigned INDEX_W = 6;

  // Register reset values.
  localparam logic [15:0] NOISE_GATE_RST = 16'd50;
  localparam logic [7:0]  FLOOR_RISE_RST = 8'd2;
  localparam logic [3:0]  DROP_SHIFT_RST = 4'd3;
  localparam logic [15:0] SILENCE_RST = 16'd200;
  localparam logic [3:0]  WARMUP_RST = 4'd7;

  // Register addresses (word index).
  localparam logic [2:0] REG_NOISE_GATE = 3'd0;
  localparam logic [2:0] REG_FLOOR_RISE = 3'd1;
  localparam logic [2:0] REG_DROP_SHIFT = 3'd2;
  localparam logic [2:0] REG_SILENCE = 3'd3;
  localparam logic [2:0] REG_WARMUP = 3'd4;

  localparam logic [MASK_W-1:0] MASK_FULL = 7'h7F;
  localparam logic [MASK_W-1:0] MASK_BASE = 7'h40;
  localparam logic [2:0] HEIGHT_MAX = 3'd7;

  // Divider request from the sequencer.
  typedef struct packed {
    logic        start;
    logic [18:0] num;
    logic [16:0] den;
  } div_req_t;

  // Divider response.
  typedef struct packed {
    logic       done;
    logic [2:0] height;
  } div_rsp_t;

  // Column mask from a height.
  function automatic logic [MASK_W-1:0] height_mask(input logic [2:0] h);
    logic [MASK_W-1:0] m;
    m = MASK_FULL << (HEIGHT_MAX - h);
    return (h == 3'd0) ? MASK_BASE : m;
  endfunction

endpackage

[hdl/audio_level_scope_columns_unit.sv]
// Top level of the audio level scope column generator: sequencer, registers and ring.
//
//  Channel | Signals                                          | Direction
//  in      | in_valid in_ready tx_active ptt_held display_enabled amplitude | request in
//  out     | out_valid out_ready column_index column_mask last_column | request out
//  cfg     | psel penable pwrite paddr pwdata prdata pready    | APB slave
//
// A request with tx_active low or ptt_held low is taken without storing a sample. A
// stored sample passes through S_RD and S_WR. A displayed frame adds a min/max pass
// through the single ring port and the floor update, then one division per column in
// the shared divider. After reset, and at each session start, the ring is refilled one
// slot a cycle while no request is taken. Output stalls hold the sequencer.
module audio_level_scope_columns_unit #(
  parameter int unsigned COLUMNS = alsc_pkg::COLUMNS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        tx_active,
  input  logic        ptt_held,
  input  logic        display_enabled,
  input  logic [15:0] amplitude,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  column_index,
  output logic [6:0]  column_mask,
  output logic        last_column,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(COLUMNS);
  localparam logic [AW-1:0] LAST = AW'(COLUMNS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_WR, S_SCAN, S_FLOOR, S_COLRD, S_COLDIV,
    S_COLWAIT, S_EMIT
  } state_t;

  state_t state;
  logic [15:0] noise_gate, silence_level;
  logic [7:0]  floor_rise;
  logic [3:0]  floor_drop_shift, warmup_frames, warmup_count;
  logic [AW-1:0] write_slot, ptr, cnt;
  logic [15:0] floor_level, mn, mx, sample;
  logic        in_session, disp, scan_first, scan_prime;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0] ram_wdata, ram_rdata;
  alsc_pkg::div_req_t dreq;
  alsc_pkg::div_rsp_t drsp;
  logic [15:0] range;
  logic        gate_ok;
  logic [16:0] gap_sh;
  logic [16:0] drop;
  logic [16:0] rise;
  logic        hold_new;
  logic [15:0] slot_val, wr_val;

  // Register port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_gate <= alsc_pkg::NOISE_GATE_RST;
      floor_rise <= alsc_pkg::FLOOR_RISE_RST;
      floor_drop_shift <= alsc_pkg::DROP_SHIFT_RST;
      silence_level <= alsc_pkg::SILENCE_RST;
      warmup_frames <= alsc_pkg::WARMUP_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        alsc_pkg::REG_NOISE_GATE: noise_gate <= pwdata[15:0];
        alsc_pkg::REG_FLOOR_RISE: floor_rise <= pwdata[7:0];
        alsc_pkg::REG_DROP_SHIFT: floor_drop_shift <= pwdata[3:0];
        alsc_pkg::REG_SILENCE: silence_level <= pwdata[15:0];
        alsc_pkg::REG_WARMUP: warmup_frames <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[4:2])
      alsc_pkg::REG_NOISE_GATE: prdata = {16'b0, noise_gate};
      alsc_pkg::REG_FLOOR_RISE: prdata = {24'b0, floor_rise};
      alsc_pkg::REG_DROP_SHIFT: prdata = {28'b0, floor_drop_shift};
      alsc_pkg::REG_SILENCE: prdata = {16'b0, silence_level};
      alsc_pkg::REG_WARMUP: prdata = {28'b0, warmup_frames};
      default: prdata = '0;
    endcase
  end

  alsc_ram #(.WIDTH(16), .DEPTH(COLUMNS)) u_ring (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  alsc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Floor update arithmetic.
  assign gap_sh = {1'b0, (floor_level - mn) >> floor_drop_shift} + 17'd1;
  assign drop = (gap_sh > {1'b0, floor_level}) ? 17'd0 : {1'b0, floor_level} - gap_sh;
  assign rise = {1'b0, floor_level} + {9'b0, floor_rise};
  assign range = (mx > floor_level) ? mx - floor_level : 16'd0;
  assign gate_ok = (range >= noise_gate) && (range != 16'd0);

  // Sample to store: new reading after warm-up, else old value; zero becomes silence.
  assign slot_val = hold_new ? sample : ram_rdata;
  assign wr_val = (slot_val == 16'd0) ? silence_level : slot_val;

  // Ring port and divider request.
  always_comb begin
    ram_we = 1'b0;
    ram_addr = ptr;
    ram_wdata = wr_val;
    dreq = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_wdata = silence_level;
      end
      S_WR: ram_we = 1'b1;
      default: ;
    endcase
    if (state == S_COLDIV) begin
      dreq.start = 1'b1;
      dreq.num = (ram_rdata > floor_level) ? 19'(ram_rdata - floor_level) * 19'd7 : 19'd0;
      dreq.den = {1'b0, range};
    end
  end

  assign in_ready = (state == S_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr <= '0;
      write_slot <= '0;
      floor_level <= alsc_pkg::SILENCE_RST;
      in_session <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (ptr == LAST) begin
            ptr <= write_slot;
            // A session start goes on to store its sample; after reset the block idles.
            state <= in_session ? S_RD : S_IDLE;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            disp <= display_enabled;
            sample <= amplitude;
            if (!tx_active) begin
              in_session <= 1'b0;
            end else if (ptt_held) begin
              if (!in_session) begin
                in_session <= 1'b1;
                write_slot <= '0;
                floor_level <= silence_level;
                ptr <= '0;
                state <= S_CLEAR;
              end else begin
                ptr <= write_slot;
                state <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          // Wait for the old slot value.
          state <= S_WR;
        end
        S_WR: begin
          // Slot write-back stores the new reading, or during warm-up the old value read in S_RD.
          write_slot <= (ptr == LAST) ? '0 : ptr + AW'(1);
          if (disp) begin
            cnt <= '0;
            scan_first <= 1'b1;
            scan_prime <= 1'b1;
            ptr <= '0;
            state <= S_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          // The RAM read is registered, so the first pass through S_SCAN only primes the read.
          ptr <= (ptr == LAST) ? '0 : ptr + AW'(1);
          if (scan_prime) begin
            scan_prime <= 1'b0;
          end else begin
            if (!scan_first) begin
              if (ram_rdata < mn) mn <= ram_rdata;
              if (ram_rdata > mx) mx <= ram_rdata;
            end else begin
              mn <= ram_rdata;
              mx <= ram_rdata;
            end
            scan_first <= 1'b0;
            if (cnt == LAST) begin
              state <= S_FLOOR;
            end else begin
              cnt <= cnt + AW'(1);
            end
          end
        end
        S_FLOOR: begin
          if (floor_level > mn) begin
            floor_level <= drop[15:0];
          end else begin
            floor_level <= rise[16] ? 16'hFFFF : rise[15:0];
          end
          ptr <= write_slot;
          cnt <= '0;
          state <= S_COLRD;
        end
        S_COLRD: state <= S_COLDIV;
        S_COLDIV: state <= S_COLWAIT;
        S_COLWAIT: begin
          if (drsp.done) begin
            column_mask <= alsc_pkg::height_mask(gate_ok ? drsp.height : 3'd0);
            column_index <= 6'(cnt);
            last_column <= (cnt == LAST);
            out_valid <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (cnt == LAST) begin
              state <= S_IDLE;
            end else begin
              cnt <= cnt + AW'(1);
              ptr <= (ptr == LAST) ? '0 : ptr + AW'(1);
              state <= S_COLRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Warm-up count rises once per stored frame until it reaches the register value.
  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_count <= '0;
    end else if (state == S_RD && warmup_count < warmup_frames) begin
      warmup_count <= warmup_count + 4'd1;
    end
  end

  // Whether this frame stores its new reading, decided before the count moves.
  always_ff @(posedge clk) begin
    if (state == S_RD) hold_new <= (warmup_count >= warmup_frames);
  end

  property p_ready_idle;
    @(posedge clk) disable iff (rst) in_ready |-> !out_valid;
  endproperty
  a_ready_idle: assert property (p_ready_idle)
    else $error("input ready while a column is pending");

  property p_last_idx;
    @(posedge clk) disable iff (rst) out_valid && last_column |-> column_index == 6'(LAST);
  endproperty
  a_last_idx: assert property (p_last_idx)
    else $error("last column flag on the wrong column");

  property p_hold;
    @(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid && $stable(column_mask);
  endproperty
  a_hold: assert property (p_hold)
    else $error("column dropped while stalled");

endmodule

[hdl/alsc_ram.sv]
// Generic single-port RAM with a registered read.
module alsc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 43
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One address per cycle: a write when we is high, and always a read of the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/alsc_div.sv]
// Restoring divider that computes min(num / den, 7) one quotient bit per cycle.
module alsc_div (
  input  logic               clk,
  input  logic               rst,
  input  alsc_pkg::div_req_t req,
  output alsc_pkg::div_rsp_t rsp
);

  logic [18:0] rem;
  logic [16:0] den;
  logic [2:0]  quo;
  logic [1:0]  step;
  logic        busy;
  logic        sat;
  logic [19:0] trial;

  // Trial subtraction of the shifted divisor.
  assign trial = {1'b0, rem} - ({3'b0, den} << step);

  // Quotient is saturated at 7 when num >= 8*den, checked up front.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp <= '0;
    end else if (req.start) begin
      rem  <= req.num;
      den  <= req.den;
      quo  <= '0;
      step <= 2'd2;
      busy <= 1'b1;
      sat  <= ({1'b0, req.num} >= ({3'b0, req.den} << 3));
      rsp.done <= 1'b0;
    end else if (busy) begin
      if (!trial[19]) begin
        rem <= trial[18:0];
      end
      quo[step] <= !trial[19];
      if (step == 2'd0) begin
        busy <= 1'b0;
        rsp.done <= 1'b1;
        rsp.height <= sat ? alsc_pkg::HEIGHT_MAX : {quo[2:1], !trial[19]};
      end else begin
        step <= step - 2'd1;
        rsp.done <= 1'b0;
      end
    end else begin
      rsp.done <= 1'b0;
    end
  end

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) rsp.done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy)
    else $error("divider finished without running");

  property p_busy_start;
    @(posedge clk) disable iff (rst) $past(req.start) && !$past(rst) |-> busy;
  endproperty
  a_busy_start: assert property (p_busy_start)
    else $error("divider did not start");

  property p_step_range;
    @(posedge clk) disable iff (rst) busy |-> step <= 2'd2;
  endproperty
  a_step_range: assert property (p_step_range)
    else $error("divider step out of range");

endmodule
